// ----- sv/o4rec_pkg.sv -----
// Shared types, constants and the microcode program of the order-4 recurrence core.
`timescale 1ns / 1ps

package o4rec_pkg;

    // Fixed field widths of the two channels.
    localparam int IN_W  = 31;
    localparam int OUT_W = 10;

    // Defaults for the top-level parameters.
    localparam int DEF_MODULUS    = 1009;
    localparam int DEF_INDEX_BITS = 31;

    // Matrix store: three slots of sixteen entries, addressed as {slot, row, column}.
    localparam int SLOT_W    = 2;
    localparam int ADDR_W    = SLOT_W + 4;
    localparam int MEM_DEPTH = 48;

    localparam logic [SLOT_W-1:0] SLOT_ACC  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_BASE = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_FREE = 2'd2;

    // Sequencer step addresses.
    typedef enum logic [3:0] {
        S_FETCH = 4'd0,
        S_CHECK = 4'd1,
        S_INIT  = 4'd2,
        S_TEST  = 4'd3,
        S_MUL   = 4'd4,
        S_MWAIT = 4'd5,
        S_SHIFT = 4'd6,
        S_SQR   = 4'd7,
        S_SWAIT = 4'd8,
        S_LOOP  = 4'd9,
        S_FIN   = 4'd10,
        S_FWAIT = 4'd11,
        S_OUT   = 4'd12,
        S_DONE  = 4'd13,
        S_SMALL = 4'd14,
        S_SDONE = 4'd15
    } step_t;

    // Datapath operation of a control word.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_FETCH     = 4'd1,
        OP_INIT      = 4'd2,
        OP_MUL       = 4'd3,
        OP_SQR       = 4'd4,
        OP_FIN       = 4'd5,
        OP_SHIFT     = 4'd6,
        OP_OUT_SUM   = 4'd7,
        OP_OUT_SMALL = 4'd8
    } op_t;

    // Jump condition of a control word; when it is false the step counter advances.
    typedef enum logic [3:0] {
        C_NEVER     = 4'd0,
        C_ALWAYS    = 4'd1,
        C_NO_IN     = 4'd2,
        C_SMALL     = 4'd3,
        C_INIT_MORE = 4'd4,
        C_BIT_CLR   = 4'd5,
        C_BUSY      = 4'd6,
        C_EXP_DONE  = 4'd7,
        C_OUT_FULL  = 4'd8
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucw_t;

    // Tag that travels with each product term through the multiply pipeline.
    typedef struct packed {
        logic              first;
        logic              last;
        logic              fin;
        logic [ADDR_W-1:0] waddr;
    } tag_t;

    // The program. Waits are jumps to the same step.
    function automatic ucw_t ucode(input step_t s);
        ucw_t w;
        w = '{OP_NONE, C_NEVER, S_FETCH};
        unique case (s)
            S_FETCH: w = '{OP_FETCH,     C_NO_IN,     S_FETCH};
            S_CHECK: w = '{OP_NONE,      C_SMALL,     S_SMALL};
            S_INIT:  w = '{OP_INIT,      C_INIT_MORE, S_INIT};
            S_TEST:  w = '{OP_NONE,      C_BIT_CLR,   S_SHIFT};
            S_MUL:   w = '{OP_MUL,       C_NEVER,     S_FETCH};
            S_MWAIT: w = '{OP_NONE,      C_BUSY,      S_MWAIT};
            S_SHIFT: w = '{OP_SHIFT,     C_EXP_DONE,  S_FIN};
            S_SQR:   w = '{OP_SQR,       C_NEVER,     S_FETCH};
            S_SWAIT: w = '{OP_NONE,      C_BUSY,      S_SWAIT};
            S_LOOP:  w = '{OP_NONE,      C_ALWAYS,    S_TEST};
            S_FIN:   w = '{OP_FIN,       C_NEVER,     S_FETCH};
            S_FWAIT: w = '{OP_NONE,      C_BUSY,      S_FWAIT};
            S_OUT:   w = '{OP_OUT_SUM,   C_OUT_FULL,  S_OUT};
            S_DONE:  w = '{OP_NONE,      C_ALWAYS,    S_FETCH};
            S_SMALL: w = '{OP_OUT_SMALL, C_OUT_FULL,  S_SMALL};
            S_SDONE: w = '{OP_NONE,      C_ALWAYS,    S_FETCH};
        endcase
        return w;
    endfunction

    // Non-zero entries of the companion matrix, by {row, column}.
    function automatic logic is_companion(input logic [3:0] idx);
        logic r;
        r = (idx == 4'd3) || (idx == 4'd4) || (idx == 4'd9) || (idx == 4'd14)
            || (idx == 4'd15);
        return r;
    endfunction

endpackage

// ----- sv/order4_recurrence_term_by_matrix_power_core.sv -----
// Top level: term n of t(i) = t(i-1) + t(i-4) by modular 4x4 matrix powering.
`timescale 1ns / 1ps

// Channel      Fields       Handshake
// ----------   ----------   -----------------------------------------
// term_index   term_index   term_index_valid / term_index_stall
// term_value   term_value   term_value_valid / term_value_stall
//
// Indices of 4 or less are answered directly. Larger indices take P matrix
// products of the square-and-multiply ladder (ones of n-4 plus its bit length
// less one, at most 60 for 31-bit indices). Each product is 64
// multiply-accumulate issues on the single shared multiply-reduce pipeline plus
// its drain. Reset clears the sequencer, the pipeline valid bits and the output
// valid bit; the matrix store is refilled by a 32-entry sweep for every index
// above 4. A new index is taken only in the fetch step, but the finished result
// waits in the output register, so the next transaction is taken while it is
// stalled.

module order4_recurrence_term_by_matrix_power_core
    import o4rec_pkg::*;
#(
    parameter int MODULUS    = DEF_MODULUS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  term_index,
    input  logic             term_index_valid,
    output logic             term_index_stall,
    output logic [OUT_W-1:0] term_value,
    output logic             term_value_valid,
    input  logic             term_value_stall
);

    // Residue width, and the widths of the Barrett reduction.
    localparam int RW  = $clog2(MODULUS);
    localparam int PW  = 2 * RW;
    localparam int BW  = PW + RW + 1;
    localparam int DW  = PW + 2;
    localparam int RRW = RW + 2;
    localparam int NB  = (INDEX_BITS < IN_W) ? INDEX_BITS : IN_W;

    localparam longint unsigned MU_L = (64'd1 << PW) / MODULUS;
    localparam logic [RW:0]     MU       = MU_L[RW:0];
    localparam logic [RW:0]     MOD_W1   = (RW + 1)'(MODULUS);
    localparam logic [DW-1:0]   MOD_DW   = DW'(MODULUS);
    localparam logic [RRW-1:0]  MOD_R    = RRW'(MODULUS);
    localparam logic [RRW-1:0]  MOD2_R   = RRW'(2 * MODULUS);
    localparam logic [RW-1:0]   ONE_MOD  = RW'(1 % MODULUS);
    localparam logic [RW-1:0]   TWO_MOD  = RW'(2 % MODULUS);
    localparam logic [NB-1:0]   N_FOUR   = NB'(4);

    // ------------------------------------------------------------------
    // Sequencer state and control word decode.
    // ------------------------------------------------------------------
    step_t pc_reg, pc_next;
    ucw_t  ucw;
    logic [3:0] pc_inc;

    logic [NB-1:0]     exp_reg;
    logic              small_reg;
    logic              four_reg;
    logic [4:0]        init_cnt_reg;
    logic [SLOT_W-1:0] a_slot_reg, b_slot_reg, f_slot_reg;

    logic do_fetch, do_init, do_mul, do_sqr, do_fin, do_shift, do_out_sum, do_out_small;
    logic cond_true;
    logic in_fire, out_full, eng_busy;

    // Multiply-accumulate engine.
    logic              issuing_reg;
    logic [5:0]        cnt_reg;
    logic [SLOT_W-1:0] eng_x_reg, eng_y_reg, eng_w_reg;
    logic              eng_fin_reg;
    logic              issue_last;
    logic [1:0]        k_idx;
    logic [ADDR_W-1:0] ra0, ra1;
    tag_t              issue_tag;

    // Matrix store.
    logic [RW-1:0]     mem [0:MEM_DEPTH-1];
    logic [RW-1:0]     rd0_reg, rd1_reg;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [RW-1:0]     wdata;
    logic [RW-1:0]     init_data;

    // Pipeline stages: memory read, product, quotient estimate, remainder, corrected.
    logic m_valid_reg, p_valid_reg, q_valid_reg, r_valid_reg, c_valid_reg;
    tag_t m_tag_reg, p_tag_reg, q_tag_reg, r_tag_reg, c_tag_reg;

    logic [RW-1:0]  op_b;
    logic [PW-1:0]  prod_reg;
    logic [BW-1:0]  bq_full;
    logic [RW-1:0]  q_reg;
    logic [PW-1:0]  x_reg;
    logic [DW-1:0]  diff;
    logic [RRW-1:0] r_reg;
    logic [RW-1:0]  pr_reg;
    logic [RW:0]    acc_sum;
    logic [RW-1:0]  sum;
    logic [RW-1:0]  acc_reg;
    logic [RW-1:0]  result_reg;

    // Output register.
    logic             out_valid_reg;
    logic [RW-1:0]    term_value_reg;
    logic [RW+OUT_W-1:0] out_ext;

    logic [NB-1:0] n_in;

    assign n_in     = term_index[NB-1:0];
    assign in_fire  = term_index_valid && (pc_reg == S_FETCH);
    assign out_full = out_valid_reg && term_value_stall;
    assign eng_busy = issuing_reg || m_valid_reg || p_valid_reg || q_valid_reg
                      || r_valid_reg || c_valid_reg;

    assign term_index_stall = (pc_reg != S_FETCH);
    assign term_value_valid = out_valid_reg;
    assign out_ext          = {{OUT_W{1'b0}}, term_value_reg};
    assign term_value       = out_ext[OUT_W-1:0];

    // Control word outputs.
    always_comb
    begin
        ucw          = ucode(pc_reg);
        do_fetch     = 1'b0;
        do_init      = 1'b0;
        do_mul       = 1'b0;
        do_sqr       = 1'b0;
        do_fin       = 1'b0;
        do_shift     = 1'b0;
        do_out_sum   = 1'b0;
        do_out_small = 1'b0;
        unique case (ucw.op)
            OP_NONE:      ;
            OP_FETCH:     do_fetch     = in_fire;
            OP_INIT:      do_init      = 1'b1;
            OP_MUL:       do_mul       = 1'b1;
            OP_SQR:       do_sqr       = 1'b1;
            OP_FIN:       do_fin       = 1'b1;
            OP_SHIFT:     do_shift     = 1'b1;
            OP_OUT_SUM:   do_out_sum   = !out_full;
            OP_OUT_SMALL: do_out_small = !out_full;
            default:      ;
        endcase
    end

    // Next step: jump when the condition holds, else fall through.
    always_comb
    begin
        pc_inc = pc_reg + 4'd1;
        unique case (ucw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_IN:     cond_true = !term_index_valid;
            C_SMALL:     cond_true = small_reg;
            C_INIT_MORE: cond_true = (init_cnt_reg != 5'd31);
            C_BIT_CLR:   cond_true = !exp_reg[0];
            C_BUSY:      cond_true = eng_busy;
            C_EXP_DONE:  cond_true = (exp_reg[NB-1:1] == '0);
            C_OUT_FULL:  cond_true = out_full;
            default:     cond_true = 1'b0;
        endcase
        pc_next = cond_true ? ucw.target : step_t'(pc_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg       <= S_FETCH;
            init_cnt_reg <= '0;
            a_slot_reg   <= SLOT_ACC;
            b_slot_reg   <= SLOT_BASE;
            f_slot_reg   <= SLOT_FREE;
        end
        else
        begin
            pc_reg <= pc_next;
            if (do_fetch)
            begin
                init_cnt_reg <= '0;
                a_slot_reg   <= SLOT_ACC;
                b_slot_reg   <= SLOT_BASE;
                f_slot_reg   <= SLOT_FREE;
            end
            else if (do_init)
            begin
                init_cnt_reg <= init_cnt_reg + 5'd1;
            end
            else if (do_mul)
            begin
                // The product lands in the free slot, which becomes the accumulator.
                a_slot_reg <= f_slot_reg;
                f_slot_reg <= a_slot_reg;
            end
            else if (do_sqr)
            begin
                b_slot_reg <= f_slot_reg;
                f_slot_reg <= b_slot_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_fetch)
        begin
            exp_reg   <= n_in - N_FOUR;
            small_reg <= (n_in <= N_FOUR);
            four_reg  <= (n_in == N_FOUR);
        end
        else if (do_shift)
        begin
            exp_reg <= exp_reg >> 1;
        end
    end

    // ------------------------------------------------------------------
    // Issue side of the engine: one term X[i][k] * Y[k][j] per cycle. For the
    // closing dot product, X[k][3] is weighted by the start vector instead.
    // ------------------------------------------------------------------
    assign k_idx      = cnt_reg[1:0];
    assign issue_last = eng_fin_reg ? (k_idx == 2'd3) : (cnt_reg == 6'd63);

    always_comb
    begin
        if (eng_fin_reg)
        begin
            ra0 = {eng_x_reg, k_idx, 2'd3};
        end
        else
        begin
            ra0 = {eng_x_reg, cnt_reg[5:4], k_idx};
        end
        ra1             = {eng_y_reg, k_idx, cnt_reg[3:2]};
        issue_tag.first = (k_idx == 2'd0);
        issue_tag.last  = (k_idx == 2'd3);
        issue_tag.fin   = eng_fin_reg;
        issue_tag.waddr = {eng_w_reg, cnt_reg[5:4], cnt_reg[3:2]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_mul || do_sqr || do_fin)
            begin
                issuing_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            else if (issuing_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (issue_last)
                begin
                    issuing_reg <= 1'b0;
                end
            end
            m_valid_reg <= issuing_reg;
            p_valid_reg <= m_valid_reg;
            q_valid_reg <= p_valid_reg;
            r_valid_reg <= q_valid_reg;
            c_valid_reg <= r_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_mul)
        begin
            eng_x_reg   <= a_slot_reg;
            eng_y_reg   <= b_slot_reg;
            eng_w_reg   <= f_slot_reg;
            eng_fin_reg <= 1'b0;
        end
        else if (do_sqr)
        begin
            eng_x_reg   <= b_slot_reg;
            eng_y_reg   <= b_slot_reg;
            eng_w_reg   <= f_slot_reg;
            eng_fin_reg <= 1'b0;
        end
        else if (do_fin)
        begin
            eng_x_reg   <= a_slot_reg;
            eng_y_reg   <= a_slot_reg;
            eng_w_reg   <= f_slot_reg;
            eng_fin_reg <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Matrix store: one write port shared by the fill sweep and the engine,
    // two registered read ports.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (init_cnt_reg[4])
        begin
            init_data = is_companion(init_cnt_reg[3:0]) ? ONE_MOD : '0;
        end
        else
        begin
            init_data = (init_cnt_reg[3:2] == init_cnt_reg[1:0]) ? ONE_MOD : '0;
        end

        if (do_init)
        begin
            we    = 1'b1;
            waddr = {init_cnt_reg[4] ? b_slot_reg : a_slot_reg, init_cnt_reg[3:0]};
            wdata = init_data;
        end
        else
        begin
            we    = c_valid_reg && c_tag_reg.last && !c_tag_reg.fin;
            waddr = c_tag_reg.waddr;
            wdata = sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
    end

    // ------------------------------------------------------------------
    // Multiply and Barrett reduction: x = a * b, q ~ x * MU >> 2RW,
    // r = x - q * M lies below 3M and is brought under M by one of two subtracts.
    // ------------------------------------------------------------------
    assign op_b    = m_tag_reg.fin ? (m_tag_reg.last ? TWO_MOD : ONE_MOD) : rd1_reg;
    assign bq_full = BW'(prod_reg) * BW'(MU);
    assign diff    = DW'(x_reg) - DW'(q_reg) * MOD_DW;

    always_comb
    begin
        acc_sum = c_tag_reg.first ? {1'b0, pr_reg}
                                  : ({1'b0, acc_reg} + {1'b0, pr_reg});
        if (acc_sum >= MOD_W1)
        begin
            acc_sum = acc_sum - MOD_W1;
        end
        sum = acc_sum[RW-1:0];
    end

    always_ff @(posedge clk)
    begin
        m_tag_reg <= issue_tag;
        p_tag_reg <= m_tag_reg;
        q_tag_reg <= p_tag_reg;
        r_tag_reg <= q_tag_reg;
        c_tag_reg <= r_tag_reg;

        prod_reg <= PW'(rd0_reg) * PW'(op_b);
        q_reg    <= bq_full[PW +: RW];
        x_reg    <= prod_reg;
        r_reg    <= diff[RRW-1:0];

        priority if (r_reg >= MOD2_R)
        begin
            pr_reg <= RW'(r_reg - MOD2_R);
        end
        else if (r_reg >= MOD_R)
        begin
            pr_reg <= RW'(r_reg - MOD_R);
        end
        else
        begin
            pr_reg <= r_reg[RW-1:0];
        end

        if (c_valid_reg)
        begin
            acc_reg <= sum;
            if (c_tag_reg.last && c_tag_reg.fin)
            begin
                result_reg <= sum;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_out_sum || do_out_small)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!term_value_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_out_sum)
        begin
            term_value_reg <= result_reg;
        end
        else if (do_out_small)
        begin
            term_value_reg <= four_reg ? TWO_MOD : ONE_MOD;
        end
    end

`ifndef NO_ASSERTIONS
    a_slots_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (a_slot_reg != b_slot_reg) && (a_slot_reg != f_slot_reg)
        && (b_slot_reg != f_slot_reg))
        else $error("matrix slot pointers overlap");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (do_mul || do_sqr || do_fin) |-> !eng_busy)
        else $error("engine started while still busy");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        do_init |-> !eng_busy)
        else $error("store fill collides with engine traffic");

    a_write_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && c_tag_reg.last) |->
        ((pc_reg == S_MWAIT) || (pc_reg == S_SWAIT) || (pc_reg == S_FWAIT)))
        else $error("engine result retired outside a wait step");

    a_result_settled: assert property (@(posedge clk) disable iff (!rst_n)
        do_out_sum |-> (!eng_busy && $past(pc_reg) == S_FWAIT || $past(pc_reg) == S_OUT))
        else $error("result loaded before the dot product finished");
`endif

endmodule
